// File: rtl/core/vwcp_pkg.sv
// ----------------------------------------------------------------------------
// vwcp_pkg: shared types and constants of the variable width code packer
// Code and byte widths, the queue entry type and the code width classifier.
// ----------------------------------------------------------------------------
package vwcp_pkg;

    localparam int CODE_BITS      = 16;
    localparam int MAX_CODE_WIDTH = 16;
    localparam int BYTE_BITS      = 8;
    localparam int WIDTH_M1_BITS  = $clog2(MAX_CODE_WIDTH);
    localparam int FILL_BITS      = $clog2(BYTE_BITS);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CODE_BITS-1:0]     code_t;
    typedef logic [WIDTH_M1_BITS-1:0] width_m1_t;
    typedef logic [BYTE_BITS-1:0]     byte_t;

    // one classified code waiting for the serializer
    typedef struct packed {
        code_t     code;
        width_m1_t width_m1;  // code width minus one
    } q_item_t;

    // bit length of the dictionary size minus one, at least 0, saturated
    function automatic width_m1_t code_width_m1(input logic [CODE_BITS-1:0] dict_size);
        width_m1_t w;
        w = '0;
        for (int i = 1; i < CODE_BITS; i++) begin
            if (dict_size[i]) begin
                if (i > MAX_CODE_WIDTH - 1) begin
                    w = WIDTH_M1_BITS'(MAX_CODE_WIDTH - 1);
                end else begin
                    w = WIDTH_M1_BITS'(i);
                end
            end
        end
        return w;
    endfunction

endpackage

// File: rtl/core/vwcp_front.sv
// ----------------------------------------------------------------------------
// vwcp_front: request intake
// Takes code requests, works out the code width and pushes them to the queue.
// ----------------------------------------------------------------------------
module vwcp_front
    import vwcp_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CODE_BITS-1:0] s_code,
    input  logic [CODE_BITS-1:0] s_dict_size,
    output logic                 push_valid,
    input  logic                 push_ready,
    output q_item_t              push_item
);

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_item.code     = s_code;
        push_item.width_m1 = code_width_m1(s_dict_size);
    end

endmodule

// File: rtl/core/vwcp_queue.sv
// ----------------------------------------------------------------------------
// vwcp_queue: classified code queue
// Short first-in first-out queue between the intake and the serializer.
// ----------------------------------------------------------------------------
module vwcp_queue
    import vwcp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    output logic    push_ready,
    input  q_item_t push_item,
    output logic    pop_valid,
    input  logic    pop_ready,
    output q_item_t pop_item
);

    q_item_t                entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/vwcp_back.sv
// ----------------------------------------------------------------------------
// vwcp_back: bit serializer
// Shifts one code bit per cycle, msb first, into the byte accumulator and hands
// each completed byte to the output register, holding while that register is full and not taken.
// ----------------------------------------------------------------------------
module vwcp_back
    import vwcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  q_item_t              pop_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_BITS-1:0] m_out_byte,
    output logic                 m_last
);

    logic                 busy_reg, busy_next;
    code_t                code_reg, code_next;
    width_m1_t            idx_reg, idx_next;
    byte_t                acc_reg, acc_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic                 m_valid_reg, m_valid_next;
    byte_t                m_byte_reg, m_byte_next;
    logic                 m_last_reg, m_last_next;

    logic  cur_bit;
    byte_t acc_shift;
    logic  completes;
    logic  out_free;
    logic  step_ok;
    logic  final_step;
    logic  load;

    assign cur_bit    = code_reg[idx_reg];
    assign acc_shift  = {acc_reg[BYTE_BITS-2:0], cur_bit};
    assign completes  = (fill_reg == FILL_BITS'(BYTE_BITS - 1));
    assign out_free   = !m_valid_reg || m_tready;
    assign step_ok    = busy_reg && (!completes || out_free);
    assign final_step = step_ok && (idx_reg == '0);
    assign load       = pop_valid && (!busy_reg || final_step);
    assign pop_ready  = !busy_reg || final_step;

    always_comb begin
        busy_next    = busy_reg;
        code_next    = code_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (step_ok) begin
            acc_next  = acc_shift;
            fill_next = fill_reg + 1'b1;
            idx_next  = idx_reg - 1'b1;
            if (completes) begin
                m_valid_next = 1'b1;
                m_byte_next  = acc_shift;
                // no further byte unless a full byte of bits is still to come
                m_last_next  = (idx_reg < WIDTH_M1_BITS'(BYTE_BITS));
            end
            if (idx_reg == '0) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            code_next = pop_item.code;
            idx_next  = pop_item.width_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            fill_reg    <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            fill_reg    <= fill_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg   <= code_next;
        idx_reg    <= idx_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

endmodule

// File: rtl/core/variable_width_code_packer.sv
// ----------------------------------------------------------------------------
// variable_width_code_packer: msb first packer of variable width codes
//
//   channel  dir  tdata (low bit up)             tlast
//   s_       in   code[15:0], dict_size[31:16]   -
//   m_       out  out_byte[7:0]                  last byte of this code
//
// The serializer shifts one code bit per cycle unless held as below; a code that
// finds it idle is loaded first, one queued behind a code loads with its last bit.
// A two entry queue after the intake lets requests pile up while bits shift.
// A full output register with m_tready low holds the serializer on the bit
// that completes a byte. Reset is synchronous and clears queue, serializer,
// fill count, accumulator and output valid; a partial byte is never flushed.
// ----------------------------------------------------------------------------
module variable_width_code_packer
    import vwcp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2*CODE_BITS-1:0]   s_tdata,   // code, dict_size
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [BYTE_BITS-1:0]     m_tdata,   // out_byte
    output logic                     m_tlast    // last
);

    logic    push_valid, push_ready;
    q_item_t push_item;
    logic    pop_valid, pop_ready;
    q_item_t pop_item;

    vwcp_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_code      (s_tdata[CODE_BITS-1:0]),
        .s_dict_size (s_tdata[2*CODE_BITS-1:CODE_BITS]),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    vwcp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    vwcp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_out_byte (m_tdata),
        .m_last     (m_tlast)
    );

endmodule
